[hw/rtl/fbpa_pkg.sv]
// shared types and constants for the fixed block pool allocator
package fbpa_pkg;

	// defaults for the top-level parameters
	localparam int unsigned MAX_BLOCKS_DEF = 1024;
	localparam int unsigned LINK_BYTES_DEF = 4;

	// field widths
	localparam int unsigned CMD_W     = 2;
	localparam int unsigned INDEX_W   = 10;
	localparam int unsigned STATUS_W  = 2;
	localparam int unsigned OFFSET_W  = 26;
	localparam int unsigned BSIZE_W   = 16;
	localparam int unsigned BCOUNT_W  = 11;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 16;

	// configuration register reset values
	localparam logic [BSIZE_W-1:0]  BLOCK_SIZE_RST  = 16'd16;
	localparam logic [BCOUNT_W-1:0] BLOCK_COUNT_RST = 11'd1024;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd1;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK        = 2'd0,
		STATUS_EXHAUSTED = 2'd1,
		STATUS_BAD_INDEX = 2'd2
	} status_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_WORK = 1'b1
	} state_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [INDEX_W-1:0] block_index;
	} req_t;

	typedef struct packed {
		status_t             status;
		logic [INDEX_W-1:0]  granted_index;
		logic [OFFSET_W-1:0] data_offset;
	} rsp_t;

endpackage

[hw/rtl/fbpa_link_mem.sv]
// link memory: one write port, one read port, registered read data
module fbpa_link_mem #(
	parameter int unsigned DEPTH = fbpa_pkg::MAX_BLOCKS_DEF,
	parameter int unsigned DW    = $clog2(fbpa_pkg::MAX_BLOCKS_DEF + 1)
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DW-1:0]            wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DW-1:0]            rd_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[hw/rtl/fixed_block_pool_allocator.sv]
// top level of the fixed block pool allocator
//
// Hands out equal-size blocks of a pool by index. An allocate pops the head
// of a LIFO free list whose next links live in a link memory; when the list
// is empty it takes the next never-used block from a bump counter, and
// reports exhausted once that counter reaches block_count (capped at
// MAX_BLOCKS). A granted block comes back with its payload byte offset,
// index * (block_size + LINK_BYTES) + LINK_BYTES. A free pushes a block;
// an index at or above the bump counter is rejected and nothing changes.
// A clear returns the pool to its empty initial state. A command is taken
// in the idle state, where the accept cycle issues the link memory read and
// the state update; the work state then takes the memory data as the new
// list head and computes the offset with one multiplier. busy is high in the
// work state; the result beat shows on rsp for exactly one cycle with
// rsp_valid in the cycle after, which already accepts the next command, so
// no new command is taken until the last one has left the work state. The
// receiver cannot stall: it must take each result beat in the cycle it is
// shown. Configuration writes are always ready and are only to be issued
// while the block is idle. The link memory needs no clearing after reset.
module fixed_block_pool_allocator #(
	parameter int unsigned MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF,
	parameter int unsigned LINK_BYTES = fbpa_pkg::LINK_BYTES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// command channel
	input  logic                                start,
	output logic                                busy,
	input  fbpa_pkg::req_t                      req,
	// result channel
	output logic                                rsp_valid,
	output fbpa_pkg::rsp_t                      rsp,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [fbpa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fbpa_pkg::CFG_DAT_W-1:0]      cfg_data
);

	// head / bump width holds 0..MAX_BLOCKS, address width indexes the pool
	localparam int unsigned HW  = $clog2(MAX_BLOCKS + 1);
	localparam int unsigned AW  = $clog2(MAX_BLOCKS);
	localparam int unsigned SW  = fbpa_pkg::BSIZE_W + 1;
	localparam int unsigned PW  = AW + SW;
	localparam int unsigned MW  = (PW > fbpa_pkg::OFFSET_W) ? PW : fbpa_pkg::OFFSET_W;
	// compare widths for the index check and the count check
	localparam int unsigned XW  = (HW > fbpa_pkg::INDEX_W) ? HW : fbpa_pkg::INDEX_W;
	localparam int unsigned YW  = (HW > fbpa_pkg::BCOUNT_W) ? HW : fbpa_pkg::BCOUNT_W;

	// configuration registers
	logic [fbpa_pkg::BSIZE_W-1:0]  block_size_q;
	logic [fbpa_pkg::BCOUNT_W-1:0] block_count_q;

	// pool state
	logic [HW-1:0] free_head_q;
	logic [HW-1:0] bump_next_q;

	fbpa_pkg::state_t state_q;
	fbpa_pkg::state_t state_d;

	// stage 1: command decided in the accept cycle
	logic             pop_s1;
	logic             grant_s1;
	logic [AW-1:0]    blk_s1;
	fbpa_pkg::status_t status_s1;

	// result beat
	logic           rsp_valid_q;
	fbpa_pkg::rsp_t rsp_q;

	// accept-cycle decode
	logic              accept;
	logic              list_nonempty;
	logic              bump_ok;
	logic              index_bad;
	logic              do_pop;
	logic              do_bump;
	logic              do_push;
	logic              do_clear;
	logic              grant_d;
	logic [AW-1:0]     blk_d;
	fbpa_pkg::status_t status_d;

	// link memory ports
	logic [HW-1:0] link_rd_data;
	logic [AW-1:0] push_addr;

	// offset arithmetic
	logic [SW-1:0] stride;
	logic [PW-1:0] product;
	logic [MW-1:0] offset_full;

	assign cfg_ready = 1'b1;

	// config writes; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q  <= fbpa_pkg::BLOCK_SIZE_RST;
			block_count_q <= fbpa_pkg::BLOCK_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == fbpa_pkg::REG_BLOCK_SIZE) begin
				block_size_q <= cfg_data;
			end else if (cfg_index == fbpa_pkg::REG_BLOCK_COUNT) begin
				block_count_q <= cfg_data[fbpa_pkg::BCOUNT_W-1:0];
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fbpa_pkg::ST_IDLE: begin
				if (start) begin
					state_d = fbpa_pkg::ST_WORK;
				end
			end
			fbpa_pkg::ST_WORK: begin
				state_d = fbpa_pkg::ST_IDLE;
			end
			default: begin
				state_d = fbpa_pkg::ST_IDLE;
			end
		endcase
	end

	// fsm outputs
	always_comb begin
		busy = 1'b0;
		unique case (state_q)
			fbpa_pkg::ST_IDLE: busy = 1'b0;
			fbpa_pkg::ST_WORK: busy = 1'b1;
			default:           busy = 1'b0;
		endcase
	end

	assign accept = start && !busy;

	// head below MAX_BLOCKS means the free list holds a block
	assign list_nonempty = free_head_q < HW'(MAX_BLOCKS);
	// bump counter against the count capped at capacity
	assign bump_ok = (YW'(bump_next_q) < YW'(block_count_q)) &&
	                 (YW'(bump_next_q) < YW'(MAX_BLOCKS));
	assign index_bad = (XW'(req.block_index) >= XW'(bump_next_q)) ||
	                   (XW'(req.block_index) >= XW'(MAX_BLOCKS));

	always_comb begin
		do_pop   = 1'b0;
		do_bump  = 1'b0;
		do_push  = 1'b0;
		do_clear = 1'b0;
		grant_d  = 1'b0;
		blk_d    = free_head_q[AW-1:0];
		status_d = fbpa_pkg::STATUS_OK;
		if (accept) begin
			unique case (req.cmd)
				fbpa_pkg::CMD_ALLOC: begin
					priority if (list_nonempty) begin
						do_pop  = 1'b1;
						grant_d = 1'b1;
						blk_d   = free_head_q[AW-1:0];
					end else if (bump_ok) begin
						do_bump = 1'b1;
						grant_d = 1'b1;
						blk_d   = bump_next_q[AW-1:0];
					end else begin
						status_d = fbpa_pkg::STATUS_EXHAUSTED;
					end
				end
				fbpa_pkg::CMD_FREE: begin
					if (index_bad) begin
						status_d = fbpa_pkg::STATUS_BAD_INDEX;
					end else begin
						do_push = 1'b1;
					end
				end
				fbpa_pkg::CMD_CLEAR: begin
					do_clear = 1'b1;
				end
				default: begin
					// unused code: no change, ok status
				end
			endcase
		end
	end

	assign push_addr = AW'(req.block_index);

	fbpa_link_mem #(
		.DEPTH (MAX_BLOCKS),
		.DW    (HW)
	) u_link_mem (
		.clk     (clk),
		.wr_en   (do_push),
		.wr_addr (push_addr),
		.wr_data (free_head_q),
		.rd_en   (do_pop),
		.rd_addr (free_head_q[AW-1:0]),
		.rd_data (link_rd_data)
	);

	// control state and pool pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fbpa_pkg::ST_IDLE;
			free_head_q <= HW'(MAX_BLOCKS);
			bump_next_q <= '0;
			pop_s1      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			pop_s1      <= do_pop;
			rsp_valid_q <= (state_q == fbpa_pkg::ST_WORK);
			// pop lands when the registered link read returns (pop_s1);
			// busy keeps the next command off until then
			priority if (do_clear) begin
				free_head_q <= HW'(MAX_BLOCKS);
				bump_next_q <= '0;
			end else if (do_push) begin
				free_head_q <= HW'(req.block_index);
			end else if (do_bump) begin
				bump_next_q <= bump_next_q + 1'b1;
			end else if (pop_s1) begin
				free_head_q <= link_rd_data;
			end
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			grant_s1  <= grant_d;
			blk_s1    <= blk_d;
			status_s1 <= status_d;
		end
	end

	// payload offset: index * (block_size + link header) + link header
	assign stride      = SW'(block_size_q) + SW'(LINK_BYTES);
	assign product     = PW'(blk_s1) * PW'(stride);
	assign offset_full = MW'(product) + MW'(LINK_BYTES);

	// result beat, shown for one cycle
	always_ff @(posedge clk) begin
		if (state_q == fbpa_pkg::ST_WORK) begin
			rsp_q.status <= status_s1;
			if (grant_s1) begin
				rsp_q.granted_index <= fbpa_pkg::INDEX_W'(blk_s1);
				rsp_q.data_offset   <= offset_full[fbpa_pkg::OFFSET_W-1:0];
			end else begin
				rsp_q.granted_index <= '0;
				rsp_q.data_offset   <= '0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
